// ===== design/tpps_pkg.sv =====
package tpps_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned NpBits    = 7;
  localparam int unsigned IdxBits   = 6;

  localparam logic [NpBits-1:0] NumPointsReset = 7'd40;

  // register index taken from paddr[2]
  localparam logic RegNumPoints = 1'b0;

  typedef struct packed {
    logic signed [CoordBits-1:0] x_first;
    logic signed [CoordBits-1:0] y_first;
    logic signed [CoordBits-1:0] x_middle;
    logic signed [CoordBits-1:0] y_middle;
    logic signed [CoordBits-1:0] x_final;
    logic signed [CoordBits-1:0] y_final;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]        sample_x;
    logic signed [47:0]        sample_y;
    logic [IdxBits-1:0]        sample_index;
    logic                      last_sample;
    logic                      degenerate;
  } out_item_t;

endpackage

// ===== design/three_point_parabola_sampler.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o   | tpps_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i | tpps_pkg::out_item_t
// cfg     | input     | apb psel/penable/pready   | num_points at byte address 0
//
// an item gives num_points samples (1 to 64), a degenerate item one. out_stall_i on a
// valid result freezes the whole pipeline; otherwise it gives one result per cycle and
// the sequencer issues one sample a cycle into a 101-stage pipeline: 39 stages divide
// the abscissa by num_points, 48 stages divide the parabola value by the denominator.
// reset clears the valid bits and the sequencer and sets num_points to 40.
module three_point_parabola_sampler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tpps_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpps_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tpps_pkg::*;

  localparam int NSTG   = 101;
  localparam int K_MAG  = 1;
  localparam int K_COEF = 2;
  localparam int K_DEN  = 3;
  localparam int K_DMAG = 4;
  localparam int K_DIV0 = 2;
  localparam int DIVN   = 39;
  localparam int K_D    = 41;
  localparam int K_X    = 42;
  localparam int K_A    = 43;
  localparam int K_P    = 44;
  localparam int K_PP   = 45;
  localparam int K_T    = 46;
  localparam int K_NUM  = 47;
  localparam int K_SGN  = 48;
  localparam int K_ABS  = 49;
  localparam int K_N    = 50;
  localparam int K_BIG  = 51;
  localparam int K_Q0   = 52;
  localparam int QBITS  = 48;
  localparam int K_OUT  = 100;

  typedef struct packed {
    logic signed [15:0]  x1;
    logic signed [15:0]  y1;
    logic signed [15:0]  x2;
    logic signed [15:0]  y2;
    logic signed [15:0]  x3;
    logic signed [15:0]  y3;
    logic [5:0]          idx;
    logic                last;
    logic                degen;
    logic [6:0]          n;
    logic signed [23:0]  m;
    logic                negm;
    logic [38:0]         dvd;
    logic [6:0]          rem;
    logic [38:0]         quo;
    logic signed [16:0]  d12;
    logic signed [16:0]  d13;
    logic signed [16:0]  d23;
    logic signed [33:0]  c1;
    logic signed [33:0]  c2;
    logic signed [33:0]  c3;
    logic signed [33:0]  pd;
    logic signed [51:0]  den3;
    logic                dsgn;
    logic [50:0]         dmag;
    logic signed [40:0]  dd;
    logic signed [33:0]  xs;
    logic signed [31:0]  sx;
    logic signed [33:0]  a1;
    logic signed [33:0]  a2;
    logic signed [33:0]  a3;
    logic signed [67:0]  p12;
    logic signed [67:0]  p13;
    logic signed [67:0]  p23;
    logic signed [68:0]  l1;
    logic signed [68:0]  l2;
    logic signed [68:0]  l3;
    logic signed [67:0]  h1;
    logic signed [67:0]  h2;
    logic signed [67:0]  h3;
    logic signed [107:0] t1;
    logic signed [107:0] t2;
    logic signed [107:0] t3;
    logic signed [107:0] num;
    logic                neg;
    logic [116:0]        rq;
    logic [67:0]         dv2;
    logic                big;
    logic [47:0]         q;
    logic signed [47:0]  sy;
  } smp_t;

  logic [NpBits-1:0] num_points_q;
  logic [NpBits-1:0] n_eff;

  in_item_t          cur_q;
  logic              cur_vld_q;
  logic [5:0]        cnt_q;
  logic [6:0]        n_q;
  logic              degen_q;

  logic              vld_q [NSTG];
  smp_t              stg_q [NSTG];
  smp_t              stg_d [1:NSTG-1];
  smp_t              s0_d;

  logic              en;
  logic              emit;
  logic              cur_last;
  logic              accept;
  logic              in_degen;
  logic              cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegNumPoints) ? {25'b0, num_points_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NumPointsReset;
    end else if (cfg_wr && paddr[2] == RegNumPoints) begin
      num_points_q <= pwdata[NpBits-1:0];
    end
  end

  always_comb begin
    if (num_points_q == '0) begin
      n_eff = 7'd1;
    end else if (num_points_q > 7'(MaxPoints)) begin
      n_eff = 7'(MaxPoints);
    end else begin
      n_eff = num_points_q;
    end
  end

  // sequencer
  assign en        = !(vld_q[NSTG-1] && out_stall_i);
  assign emit      = cur_vld_q && en;
  assign cur_last  = degen_q || ({1'b0, cnt_q} == n_q - 7'd1);
  assign in_stall_o = cur_vld_q && !(emit && cur_last);
  assign accept    = in_valid_i && !in_stall_o;
  assign in_degen  = (in_data_i.x_first == in_data_i.x_middle) ||
                     (in_data_i.x_first == in_data_i.x_final) ||
                     (in_data_i.x_middle == in_data_i.x_final);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      cnt_q     <= '0;
      n_q       <= 7'd1;
      degen_q   <= 1'b0;
    end else if (accept) begin
      cur_vld_q <= 1'b1;
      cnt_q     <= '0;
      n_q       <= n_eff;
      degen_q   <= in_degen;
    end else if (emit) begin
      if (cur_last) begin
        cur_vld_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= in_data_i;
    end
  end

  always_comb begin
    s0_d       = '0;
    s0_d.x1    = cur_q.x_first;
    s0_d.y1    = cur_q.y_first;
    s0_d.x2    = cur_q.x_middle;
    s0_d.y2    = cur_q.y_middle;
    s0_d.x3    = cur_q.x_final;
    s0_d.y3    = cur_q.y_final;
    s0_d.idx   = cnt_q;
    s0_d.last  = cur_last;
    s0_d.degen = degen_q;
    s0_d.n     = n_q;
    s0_d.m     = 24'(($signed({cur_q.x_final[15], cur_q.x_final}) -
                      $signed({cur_q.x_first[15], cur_q.x_first})) *
                     $signed({1'b0, cnt_q}));
  end

  // pipeline stages
  always_comb begin
    smp_t t;
    logic [6:0] tmp7;
    int b;
    tmp7 = '0;
    b = 0;
    for (int k = 1; k < NSTG; k++) begin
      t = stg_q[k-1];
      if (k == K_MAG) begin
        t.negm = t.m[23];
        t.dvd  = {(t.m[23] ? 23'(-t.m) : t.m[22:0]), 16'b0};
        t.rem  = '0;
        t.quo  = '0;
        t.d12  = $signed({t.x1[15], t.x1}) - $signed({t.x2[15], t.x2});
        t.d13  = $signed({t.x1[15], t.x1}) - $signed({t.x3[15], t.x3});
        t.d23  = $signed({t.x2[15], t.x2}) - $signed({t.x3[15], t.x3});
      end
      if (k >= K_DIV0 && k < K_DIV0 + DIVN) begin
        tmp7  = {t.rem[5:0], t.dvd[38]};
        t.dvd = {t.dvd[37:0], 1'b0};
        if (tmp7 >= t.n) begin
          t.rem = tmp7 - t.n;
          t.quo = {t.quo[37:0], 1'b1};
        end else begin
          t.rem = tmp7;
          t.quo = {t.quo[37:0], 1'b0};
        end
      end
      if (k == K_COEF) begin
        t.c1 = t.y1 * t.d23;
        t.c2 = t.y2 * t.d13;
        t.c3 = t.y3 * t.d12;
        t.pd = t.d12 * t.d13;
      end
      if (k == K_DEN) begin
        t.c2   = -t.c2;
        t.den3 = t.pd * t.d23;
      end
      if (k == K_DMAG) begin
        t.dsgn = t.den3[51];
        t.dmag = t.den3[51] ? 51'(-t.den3) : t.den3[50:0];
      end
      if (k == K_D) begin
        t.dd = t.negm ? -$signed({2'b0, t.quo}) - $signed({40'b0, t.rem != 7'd0})
                      : $signed({2'b0, t.quo});
      end
      if (k == K_X) begin
        t.xs = 34'($signed({t.x1, 16'b0}) + t.dd);
        if (t.xs > 34'sd2147483647) begin
          t.sx = 32'h7FFF_FFFF;
        end else if (t.xs < -34'sd2147483648) begin
          t.sx = 32'h8000_0000;
        end else begin
          t.sx = t.xs[31:0];
        end
      end
      if (k == K_A) begin
        t.a1 = t.xs - 34'($signed({t.x1, 16'b0}));
        t.a2 = t.xs - 34'($signed({t.x2, 16'b0}));
        t.a3 = t.xs - 34'($signed({t.x3, 16'b0}));
      end
      if (k == K_P) begin
        t.p12 = t.a1 * t.a2;
        t.p13 = t.a1 * t.a3;
        t.p23 = t.a2 * t.a3;
      end
      if (k == K_PP) begin
        t.l1 = t.c1 * $signed({1'b0, t.p23[33:0]});
        t.l2 = t.c2 * $signed({1'b0, t.p13[33:0]});
        t.l3 = t.c3 * $signed({1'b0, t.p12[33:0]});
        t.h1 = t.c1 * $signed(t.p23[67:34]);
        t.h2 = t.c2 * $signed(t.p13[67:34]);
        t.h3 = t.c3 * $signed(t.p12[67:34]);
      end
      if (k == K_T) begin
        t.t1 = (108'(t.h1) <<< 34) + 108'(t.l1);
        t.t2 = (108'(t.h2) <<< 34) + 108'(t.l2);
        t.t3 = (108'(t.h3) <<< 34) + 108'(t.l3);
      end
      if (k == K_NUM) begin
        t.num = t.t1 + t.t2 + t.t3;
      end
      if (k == K_SGN) begin
        if (t.dsgn) begin
          t.num = -t.num;
        end
      end
      if (k == K_ABS) begin
        t.neg = t.num[107];
        t.rq  = {9'b0, (t.num[107] ? 108'(-t.num) : 108'(t.num))};
      end
      if (k == K_N) begin
        // round half away from zero: (2M + D) / 2D
        t.rq  = {t.rq[115:0], 1'b0} + {50'b0, t.dmag, 16'b0};
        t.dv2 = {t.dmag, 17'b0};
        t.q   = '0;
      end
      if (k == K_BIG) begin
        t.big = t.rq >= {1'b0, t.dv2, 48'b0};
      end
      if (k >= K_Q0 && k < K_Q0 + QBITS) begin
        b = QBITS - 1 - (k - K_Q0);
        if (t.rq >= ({49'b0, t.dv2} << b)) begin
          t.rq   = t.rq - ({49'b0, t.dv2} << b);
          t.q[b] = 1'b1;
        end
      end
      if (k == K_OUT) begin
        if (!t.neg) begin
          t.sy = (t.big || t.q[47]) ? 48'sh7FFF_FFFF_FFFF : $signed(t.q);
        end else begin
          t.sy = (t.big || (t.q[47] && t.q[46:0] != '0)) ? 48'sh8000_0000_0000
                                                         : $signed(48'(-t.q));
        end
        if (t.degen) begin
          t.sy = '0;
          t.sx = '0;
        end
      end
      stg_d[k] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= emit;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= s0_d;
      for (int k = 1; k < NSTG; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_valid_o             = vld_q[NSTG-1];
  assign out_data_o.sample_x     = stg_q[NSTG-1].sx;
  assign out_data_o.sample_y     = stg_q[NSTG-1].sy;
  assign out_data_o.sample_index = stg_q[NSTG-1].idx;
  assign out_data_o.last_sample  = stg_q[NSTG-1].last;
  assign out_data_o.degenerate   = stg_q[NSTG-1].degen;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tpps_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam longint SampleMax = (64'sd1 <<< 47) - 1;
  localparam int     TimeLimit = 1000000;
  localparam int     DrainWait = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  in_item_t  point_q[$];
  out_item_t sample_q[$];
  logic [NpBits-1:0] num_points = NumPointsReset;
  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  int  mismatches = 0;
  int  cycle = 0;

  three_point_parabola_sampler uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  // exact parabola value at each quantized abscissa, rounded and saturated
  function automatic void predict_samples(in_item_t it);
    longint x1, x2, x3, n, xs;
    wide_t  y1, y2, y3, d12, d13, d23, a1, a2, a3, den, num, mag, quo;
    logic   neg;
    out_item_t o;
    x1 = it.x_first;
    x2 = it.x_middle;
    x3 = it.x_final;
    y1 = it.y_first;
    y2 = it.y_middle;
    y3 = it.y_final;
    n = num_points;
    if (n < 1) n = 1;
    if (n > MaxPoints) n = MaxPoints;
    if (x1 == x2 || x1 == x3 || x2 == x3) begin
      o = '0;
      o.last_sample = 1'b1;
      o.degenerate = 1'b1;
      sample_q.push_back(o);
      return;
    end
    d12 = x1 - x2;
    d13 = x1 - x3;
    d23 = x2 - x3;
    den = d12 * d13 * d23 * wide_t'(65536);
    for (longint i = 0; i < n; i++) begin
      xs = x1 * 65536 + floor_div((x3 - x1) * i * 65536, n);
      a1 = xs - x1 * 65536;
      a2 = xs - x2 * 65536;
      a3 = xs - x3 * 65536;
      num = y1 * d23 * a2 * a3 - y2 * d13 * a1 * a3 + y3 * d12 * a1 * a2;
      mag = den;
      if (den < 0) begin
        num = -num;
        mag = -den;
      end
      neg = num < 0;
      if (neg) num = -num;
      quo = (2 * num + mag) / (2 * mag);
      o = '0;
      if (!neg) o.sample_y = (quo > SampleMax) ? SampleMax : quo[47:0];
      else o.sample_y = (quo > SampleMax + 1) ? -SampleMax - 1 : -quo[47:0];
      if (xs > 64'sd2147483647) xs = 64'sd2147483647;
      if (xs < -64'sd2147483648) xs = -64'sd2147483648;
      o.sample_x = xs[31:0];
      o.sample_index = i[IdxBits-1:0];
      o.last_sample = (i == n - 1);
      sample_q.push_back(o);
    end
  endfunction

  // point sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_samples(in_data_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (point_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= point_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // sample checker
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample %p", out_data_o);
        end else begin
          out_item_t e;
          e = sample_q.pop_front();
          if (out_data_o.sample_x !== e.sample_x || out_data_o.sample_y !== e.sample_y ||
              out_data_o.sample_index !== e.sample_index ||
              out_data_o.last_sample !== e.last_sample ||
              out_data_o.degenerate !== e.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: expected %p actual %p", e, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle >= TimeLimit) begin
      $display("three_point_parabola_sampler regression: fail");
      $finish;
    end
  end

  task automatic write_num_points(logic [NpBits-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegNumPoints, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    num_points = value;
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_valid_i || sample_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic in_item_t pt(int a, int b, int c, int d, int e, int f);
    in_item_t it;
    it.x_first = 16'(a);
    it.y_first = 16'(b);
    it.x_middle = 16'(c);
    it.y_middle = 16'(d);
    it.x_final = 16'(e);
    it.y_final = 16'(f);
    return it;
  endfunction

  function automatic in_item_t random_points();
    in_item_t it;
    int k;
    it = {$urandom, $urandom, $urandom};
    k = $urandom_range(9);
    if (k < 3) begin
      it.x_middle = it.x_first + $signed(16'($urandom_range(200))) - 16'sd100;
      it.x_final = it.x_first + $signed(16'($urandom_range(400))) - 16'sd200;
    end else if (k == 3) begin
      it.x_middle = it.x_first;
    end else if (k == 4) begin
      it.x_final = ($urandom_range(1)) ? it.x_first : it.x_middle;
    end
    return it;
  endfunction

  initial begin
    logic [NpBits-1:0] np_list[9];
    np_list = '{7'd40, 7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd17, 7'd5, 7'd2};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 13;
    receiver_idle_pct = 45;
    point_q.push_back(pt(-32768, 32767, 0, -32768, 32767, 32767));
    point_q.push_back(pt(32767, -32768, 0, 32767, -32768, -32768));
    point_q.push_back(pt(-32768, 32767, -32767, -32768, 32767, 32767));
    point_q.push_back(pt(-32768, -32768, -32767, 32767, 32767, -32768));
    point_q.push_back(pt(32767, 32767, 32766, -32768, -32768, 32767));
    point_q.push_back(pt(0, 0, 1, 1, 2, 4));
    point_q.push_back(pt(5, 7, 5, 3, 9, 1));
    point_q.push_back(pt(5, 7, 8, 3, 5, 1));
    point_q.push_back(pt(2, 7, 8, 3, 8, 1));
    point_q.push_back(pt(-1, -1, -1, -1, -1, -1));
    point_q.push_back(pt(10, -5, 3, 2, -4, 9));
    point_q.push_back(pt(-1, 0, 0, -1, 1, 0));
    point_q.push_back(pt(0, 0, 0, 0, 0, 0));
    point_q.push_back(pt(100, 32767, -100, 32767, 0, -32768));
    drain();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        sender_idle_pct = 45;
        receiver_idle_pct = 13;
      end else if (p == 6) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      write_num_points(np_list[p]);
      for (int j = 0; j < 38; j++) point_q.push_back(random_points());
      drain();
    end
    write_num_points(NumPointsReset);

    if (mismatches == 0) begin
      $display("three_point_parabola_sampler regression: pass");
    end else begin
      $display("three_point_parabola_sampler regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tpps_pkg.sv
design/three_point_parabola_sampler.sv
bench/testbench.sv
